@@ design/led_strip_effect_generator_top_macros.svh @@
// Assertion macros for the LED strip effect generator.
// Expects signals named clk and rst in the module that includes it.
`ifndef LED_STRIP_EFFECT_GENERATOR_TOP_MACROS_SVH
`define LED_STRIP_EFFECT_GENERATOR_TOP_MACROS_SVH

// Check a condition at every clock edge outside reset
`define LSEG_ASSERT_CLK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition holds in the cycle after a trigger
`define LSEG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/lseg_pkg.sv @@
// Shared constants, types, command/status structs and constant tables
// for the LED strip effect generator. No dependencies.
package lseg_pkg;

  // Strip and sine table sizes
  localparam int LED_COUNT    = 32;
  localparam int SINE_ENTRIES = 1024;

  // Field widths
  localparam int OP_W        = 2;
  localparam int TIME_W      = 32;
  localparam int COLOR_W     = 8;
  localparam int LED_INDEX_W = 5;
  localparam int MODE_W      = 3;
  localparam int FRAME_W     = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;
  localparam int INTERVAL_W  = 7;
  localparam int FACTOR_W    = 16;

  // LED counter and hue accumulator
  localparam int IDX_W    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int REM_W    = IDX_W + 1;
  localparam int HUE_W    = 9;
  localparam int HUE_STEP = 256 / LED_COUNT;
  localparam int HUE_REM  = 256 % LED_COUNT;

  // Sine table geometry: quarter wave plus the end point
  localparam int SINE_W  = $clog2(SINE_ENTRIES);
  localparam int QUARTER = SINE_ENTRIES / 4;
  localparam int QIDX_W  = SINE_W - 1;

  localparam logic [23:0] BREATH_STEP = 24'd13671405;

  // Quarter-wave polynomial coefficients, Q30
  localparam logic [63:0] C1 = 64'd1686629713;
  localparam logic [63:0] C3 = 64'd693598668;
  localparam logic [63:0] C5 = 64'd85569306;
  localparam logic [63:0] C7 = 64'd5026995;

  // Operation codes
  localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
  localparam logic [OP_W-1:0] OP_POWER_OFF = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTORE   = 2'd2;

  // Effect modes
  localparam logic [MODE_W-1:0] MODE_OFF     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SOLID   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BREATH  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RAINBOW = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CYCLE   = 3'd4;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_EFFECT_MODE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_RED    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_GREEN  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_BLUE   = 3'd4;

  // Register reset values
  localparam logic [MODE_W-1:0]  RST_MODE  = MODE_SOLID;
  localparam logic [7:0]         RST_SPEED = 8'd128;
  localparam logic [COLOR_W-1:0] RST_RED   = 8'd255;
  localparam logic [COLOR_W-1:0] RST_GREEN = 8'd0;
  localparam logic [COLOR_W-1:0] RST_BLUE  = 8'd255;

  // Kind of frame being emitted
  typedef enum logic [2:0] {
    KIND_BLACK   = 3'd0,
    KIND_SOLID   = 3'd1,
    KIND_BREATH  = 3'd2,
    KIND_RAINBOW = 3'd3,
    KIND_CYCLE   = 3'd4
  } kind_t;

  // Controller to datapath
  typedef struct packed {
    logic  take;
    logic  start_frame;
    kind_t kind;
    logic  set_muted;
    logic  restore;
    logic  store_time;
    logic  load_phase;
    logic  load_factor;
    logic  load_scaled;
    logic  emit;
    logic  advance_frame;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic              accepted;
    logic [OP_W-1:0]   op;
    logic              muted;
    logic [MODE_W-1:0] mode;
    logic              too_early;
    logic              out_free;
    logic              last_led;
  } ctrl_status_t;

  typedef logic [INTERVAL_W-1:0] interval_tab_t [256];
  typedef logic [FACTOR_W-1:0]   qsine_tab_t [QUARTER+1];

  // Frame interval in ms for each speed setting
  function automatic interval_tab_t build_interval();
    interval_tab_t tab;
    int s;
    for (s = 0; s < 256; s++) begin
      tab[s] = INTERVAL_W'(100 - (s * 90) / 255);
    end
    return tab;
  endfunction

  // Quarter-wave sine in Q15, saturated to one
  function automatic qsine_tab_t build_qsine();
    qsine_tab_t  tab;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] qs;
    logic [63:0] s;
    int j;
    for (j = 0; j <= QUARTER; j++) begin
      t  = (64'(j) << 30) / 64'(QUARTER);
      t2 = (t * t) >> 30;
      a  = C5 - ((t2 * C7) >> 30);
      b  = C3 - ((t2 * a) >> 30);
      c  = C1 - ((t2 * b) >> 30);
      qs = (t * c) >> 30;
      s  = (qs + 64'd16384) >> 15;
      if (s > 64'd32768) begin
        s = 64'd32768;
      end
      tab[j] = s[FACTOR_W-1:0];
    end
    return tab;
  endfunction

  localparam interval_tab_t INTERVAL_TAB = build_interval();
  localparam qsine_tab_t    QSINE        = build_qsine();

endpackage

@@ design/lseg_channels.sv @@
// Handshake channel interfaces: tick input, LED output and register writes.
// Depends on lseg_pkg for field widths.
interface lseg_in_if;
  logic                          valid;
  logic                          ready;
  logic [lseg_pkg::OP_W-1:0]     operation;
  logic [lseg_pkg::TIME_W-1:0]   now_ms;
  modport source (output valid, operation, now_ms, input ready);
  modport sink (input valid, operation, now_ms, output ready);
endinterface

interface lseg_out_if;
  logic                             valid;
  logic                             ready;
  logic [lseg_pkg::LED_INDEX_W-1:0] led_index;
  logic [lseg_pkg::COLOR_W-1:0]     red;
  logic [lseg_pkg::COLOR_W-1:0]     green;
  logic [lseg_pkg::COLOR_W-1:0]     blue;
  logic                             frame_end;
  modport source (output valid, led_index, red, green, blue, frame_end, input ready);
  modport sink (input valid, led_index, red, green, blue, frame_end, output ready);
endinterface

interface lseg_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lseg_pkg::CFG_INDEX_W-1:0] index;
  logic [lseg_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/lseg_controller.sv @@
// Sequencing state machine: decodes each item and steps the datapath
// through a frame. Depends on lseg_pkg and the assertion macro header.
`include "led_strip_effect_generator_top_macros.svh"

module lseg_controller (
  input  logic                   clk,
  input  logic                   rst,
  input  lseg_pkg::ctrl_status_t status,
  output lseg_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECIDE = 6'b000010,
    ST_PHASE  = 6'b000100,
    ST_FACTOR = 6'b001000,
    ST_SCALE  = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  state_t          state;
  state_t          state_next;
  lseg_pkg::kind_t mode_kind;

  // Map the stored mode to a frame kind
  always_comb begin
    case (status.mode)
      lseg_pkg::MODE_BREATH:  mode_kind = lseg_pkg::KIND_BREATH;
      lseg_pkg::MODE_RAINBOW: mode_kind = lseg_pkg::KIND_RAINBOW;
      lseg_pkg::MODE_CYCLE:   mode_kind = lseg_pkg::KIND_CYCLE;
      default:                mode_kind = lseg_pkg::KIND_SOLID;
    endcase
  end

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.kind   = lseg_pkg::KIND_BLACK;
    case (state)
      ST_IDLE: begin
        cmd.take = 1'b1;
        if (status.accepted) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_next = ST_IDLE;
        case (status.op)
          lseg_pkg::OP_POWER_OFF: begin
            if (!status.muted) begin
              cmd.set_muted   = 1'b1;
              cmd.start_frame = 1'b1;
              state_next      = ST_EMIT;
            end
          end
          lseg_pkg::OP_RESTORE: begin
            cmd.restore = status.muted;
          end
          lseg_pkg::OP_TICK: begin
            if (!status.muted) begin
              if (status.mode == lseg_pkg::MODE_OFF) begin
                cmd.start_frame = 1'b1;
                state_next      = ST_EMIT;
              end else if (!status.too_early) begin
                cmd.store_time  = 1'b1;
                cmd.start_frame = 1'b1;
                cmd.kind        = mode_kind;
                state_next      = (mode_kind == lseg_pkg::KIND_BREATH) ? ST_PHASE : ST_EMIT;
              end
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_PHASE: begin
        cmd.load_phase = 1'b1;
        state_next     = ST_FACTOR;
      end
      ST_FACTOR: begin
        cmd.load_factor = 1'b1;
        state_next      = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.load_scaled = 1'b1;
        state_next      = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.last_led) begin
            cmd.advance_frame = 1'b1;
            state_next        = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `LSEG_ASSERT_NEXT(a_accept_to_decide, status.accepted, state == ST_DECIDE, "accepted item not decoded")
  `LSEG_ASSERT_NEXT(a_phase_then_factor, cmd.load_phase, cmd.load_factor, "sine lookup skipped")
  `LSEG_ASSERT_NEXT(a_last_to_idle, cmd.emit && status.last_led, cmd.take, "no return after last LED")

endmodule

@@ design/lseg_datapath.sv @@
// Registers, timing check, breathing factor, colour wheel and output register.
// Depends on lseg_pkg, the channel interfaces and the assertion macro header.
`include "led_strip_effect_generator_top_macros.svh"

module lseg_datapath (
  input  logic                   clk,
  input  logic                   rst,
  lseg_in_if.sink                tick,
  lseg_out_if.source             pixel,
  lseg_cfg_if.sink               cfg,
  input  lseg_pkg::ctrl_cmd_t    cmd,
  output lseg_pkg::ctrl_status_t status
);

  typedef struct packed {
    logic [lseg_pkg::COLOR_W-1:0] r;
    logic [lseg_pkg::COLOR_W-1:0] g;
    logic [lseg_pkg::COLOR_W-1:0] b;
  } rgb_t;

  // Colour wheel: three linear ramps over the hue circle
  function automatic rgb_t wheel(input logic [7:0] pos);
    rgb_t       c;
    logic [7:0] p;
    logic [7:0] q;
    logic [9:0] q3;
    p = ~pos;
    if (p < 8'd85) begin
      q = p;
    end else if (p < 8'd170) begin
      q = p - 8'd85;
    end else begin
      q = p - 8'd170;
    end
    q3 = {1'b0, q, 1'b0} + {2'b00, q};
    if (p < 8'd85) begin
      c.r = 8'd255 - q3[7:0];
      c.g = 8'd0;
      c.b = q3[7:0];
    end else if (p < 8'd170) begin
      c.r = 8'd0;
      c.g = q3[7:0];
      c.b = 8'd255 - q3[7:0];
    end else begin
      c.r = q3[7:0];
      c.g = 8'd255 - q3[7:0];
      c.b = 8'd0;
    end
    return c;
  endfunction

  // Configuration registers
  logic [lseg_pkg::MODE_W-1:0]  effect_mode;
  logic [7:0]                   speed;
  logic [lseg_pkg::COLOR_W-1:0] base_red;
  logic [lseg_pkg::COLOR_W-1:0] base_green;
  logic [lseg_pkg::COLOR_W-1:0] base_blue;

  // Block state
  logic [lseg_pkg::TIME_W-1:0]  last_frame_time;
  logic [lseg_pkg::FRAME_W-1:0] frame_count;
  logic [lseg_pkg::FRAME_W-1:0] frame_count_next;
  logic                         muted;

  // Item and frame working registers
  logic [lseg_pkg::OP_W-1:0]     op_reg;
  logic [lseg_pkg::TIME_W-1:0]   now_reg;
  lseg_pkg::kind_t               kind;
  logic [lseg_pkg::TIME_W-1:0]   phase;
  logic [lseg_pkg::FACTOR_W-1:0] factor;
  rgb_t                          scaled;
  logic [lseg_pkg::IDX_W-1:0]    led_count;
  logic [lseg_pkg::HUE_W-1:0]    hue_q;
  logic [lseg_pkg::REM_W-1:0]    hue_rem;

  // Output register
  logic                         out_valid;
  logic [lseg_pkg::LED_INDEX_W-1:0] out_index;
  rgb_t                         out_color;
  logic                         out_frame_end;

  // Combinational helpers
  logic                            cfg_accept;
  logic                            in_accept;
  logic                            last_led;
  logic                            out_free;
  logic [lseg_pkg::TIME_W-1:0]     elapsed;
  logic [39:0]                     phase_prod;
  logic [lseg_pkg::SINE_W-1:0]     sine_k;
  logic [1:0]                      quad;
  logic [lseg_pkg::QIDX_W-1:0]     sine_j;
  logic [lseg_pkg::QIDX_W-1:0]     qidx;
  logic [lseg_pkg::FACTOR_W-1:0]   qs;
  logic [lseg_pkg::FACTOR_W:0]     factor_wide;
  logic [lseg_pkg::FACTOR_W-1:0]   factor_sat;
  logic [23:0]                     prod_r;
  logic [23:0]                     prod_g;
  logic [23:0]                     prod_b;
  logic [lseg_pkg::REM_W-1:0]      rem_sum;
  logic [7:0]                      hue_pos;
  logic [lseg_pkg::IDX_W+4:0]      idx_ext;
  rgb_t                            pix;

  assign cfg.ready  = 1'b1;
  assign cfg_accept = cfg.valid && cfg.ready;
  assign tick.ready = cmd.take;
  assign in_accept  = tick.valid && tick.ready;
  assign last_led   = (led_count == lseg_pkg::IDX_W'(lseg_pkg::LED_COUNT - 1));
  assign out_free   = !out_valid || pixel.ready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      effect_mode <= lseg_pkg::RST_MODE;
      speed       <= lseg_pkg::RST_SPEED;
      base_red    <= lseg_pkg::RST_RED;
      base_green  <= lseg_pkg::RST_GREEN;
      base_blue   <= lseg_pkg::RST_BLUE;
    end else if (cfg_accept) begin
      case (cfg.index)
        lseg_pkg::REG_EFFECT_MODE: begin
          effect_mode <= (cfg.data[2:0] > lseg_pkg::MODE_CYCLE) ?
                         lseg_pkg::MODE_SOLID : cfg.data[2:0];
        end
        lseg_pkg::REG_SPEED:      speed      <= cfg.data;
        lseg_pkg::REG_BASE_RED:   base_red   <= cfg.data;
        lseg_pkg::REG_BASE_GREEN: base_green <= cfg.data;
        lseg_pkg::REG_BASE_BLUE:  base_blue  <= cfg.data;
        default: begin
          effect_mode <= effect_mode;
        end
      endcase
    end
  end

  // Frame counter advance per frame kind
  always_comb begin
    case (kind)
      lseg_pkg::KIND_BREATH: frame_count_next = frame_count + 16'd1;
      lseg_pkg::KIND_CYCLE: begin
        frame_count_next = frame_count + 16'd1;
        if (frame_count_next >= 16'd256) begin
          frame_count_next = '0;
        end
      end
      default: frame_count_next = frame_count;
    endcase
  end

  // Frame counter, mute flag and last frame time
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count     <= '0;
      muted           <= 1'b0;
      last_frame_time <= '0;
    end else begin
      if (cfg_accept && cfg.index == lseg_pkg::REG_EFFECT_MODE) begin
        frame_count <= '0;
      end else if (cmd.restore) begin
        frame_count <= '0;
      end else if (cmd.advance_frame) begin
        frame_count <= frame_count_next;
      end
      if (cmd.set_muted) begin
        muted <= 1'b1;
      end else if (cmd.restore) begin
        muted <= 1'b0;
      end
      if (cmd.store_time) begin
        last_frame_time <= now_reg;
      end
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_reg  <= tick.operation;
      now_reg <= tick.now_ms;
    end
  end

  // Frame interval check on the wrapping time difference
  assign elapsed = now_reg - last_frame_time;

  assign status.accepted  = in_accept;
  assign status.op        = op_reg;
  assign status.muted     = muted;
  assign status.mode      = effect_mode;
  assign status.too_early = elapsed <
                            {{(lseg_pkg::TIME_W - lseg_pkg::INTERVAL_W){1'b0}},
                             lseg_pkg::INTERVAL_TAB[speed]};
  assign status.out_free  = out_free;
  assign status.last_led  = last_led;

  // Breathing: phase, sine lookup and factor
  assign phase_prod  = 40'(frame_count) * 40'(lseg_pkg::BREATH_STEP);
  assign sine_k      = phase[lseg_pkg::TIME_W-1 -: lseg_pkg::SINE_W];
  assign quad        = sine_k[lseg_pkg::SINE_W-1 -: 2];
  assign sine_j      = {1'b0, sine_k[lseg_pkg::SINE_W-3:0]};
  assign qidx        = quad[0] ? (lseg_pkg::QIDX_W'(lseg_pkg::QUARTER) - sine_j) : sine_j;
  assign qs          = lseg_pkg::QSINE[qidx];
  assign factor_wide = quad[1] ? (17'd32768 - {1'b0, qs}) : (17'd32768 + {1'b0, qs});
  assign factor_sat  = factor_wide[lseg_pkg::FACTOR_W] ? '1 : factor_wide[lseg_pkg::FACTOR_W-1:0];
  assign prod_r      = 24'(base_red) * 24'(factor);
  assign prod_g      = 24'(base_green) * 24'(factor);
  assign prod_b      = 24'(base_blue) * 24'(factor);

  always_ff @(posedge clk) begin
    if (cmd.start_frame) begin
      kind <= cmd.kind;
    end
    if (cmd.load_phase) begin
      phase <= phase_prod[lseg_pkg::TIME_W-1:0];
    end
    if (cmd.load_factor) begin
      factor <= factor_sat;
    end
    if (cmd.load_scaled) begin
      scaled.r <= prod_r[23:16];
      scaled.g <= prod_g[23:16];
      scaled.b <= prod_b[23:16];
    end
  end

  // LED counter and hue accumulator: hue = index * 256 / LED_COUNT
  assign rem_sum = hue_rem + lseg_pkg::REM_W'(lseg_pkg::HUE_REM);

  always_ff @(posedge clk) begin
    if (rst) begin
      led_count <= '0;
      hue_q     <= '0;
      hue_rem   <= '0;
    end else if (cmd.start_frame) begin
      led_count <= '0;
      hue_q     <= '0;
      hue_rem   <= '0;
    end else if (cmd.emit) begin
      led_count <= last_led ? '0 : led_count + lseg_pkg::IDX_W'(1);
      if (rem_sum >= lseg_pkg::REM_W'(lseg_pkg::LED_COUNT)) begin
        hue_rem <= rem_sum - lseg_pkg::REM_W'(lseg_pkg::LED_COUNT);
        hue_q   <= hue_q + lseg_pkg::HUE_W'(lseg_pkg::HUE_STEP + 1);
      end else begin
        hue_rem <= rem_sum;
        hue_q   <= hue_q + lseg_pkg::HUE_W'(lseg_pkg::HUE_STEP);
      end
    end
  end

  // Pick the colour for the current LED
  assign hue_pos = hue_q[7:0] + ((kind == lseg_pkg::KIND_CYCLE) ? frame_count[7:0] : 8'd0);
  assign idx_ext = {5'b00000, led_count};

  always_comb begin
    case (kind)
      lseg_pkg::KIND_SOLID:   pix = '{r: base_red, g: base_green, b: base_blue};
      lseg_pkg::KIND_BREATH:  pix = scaled;
      lseg_pkg::KIND_RAINBOW: pix = wheel(hue_pos);
      lseg_pkg::KIND_CYCLE:   pix = wheel(hue_pos);
      default:                pix = '0;
    endcase
  end

  // Output register: load a new LED item, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (pixel.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_index     <= idx_ext[lseg_pkg::LED_INDEX_W-1:0];
      out_color     <= pix;
      out_frame_end <= last_led;
    end
  end

  assign pixel.valid     = out_valid;
  assign pixel.led_index = out_index;
  assign pixel.red       = out_color.r;
  assign pixel.green     = out_color.g;
  assign pixel.blue      = out_color.b;
  assign pixel.frame_end = out_frame_end;

  `LSEG_ASSERT_CLK(a_led_in_range, led_count <= lseg_pkg::IDX_W'(lseg_pkg::LED_COUNT - 1), "LED counter out of range")
  `LSEG_ASSERT_NEXT(a_last_marks_end, cmd.emit && last_led, out_valid && out_frame_end, "frame end not marked")
  `LSEG_ASSERT_CLK(a_cycle_count_range, effect_mode != lseg_pkg::MODE_CYCLE || frame_count < 16'd256, "cycle frame count wrapped late")

endmodule

@@ design/led_strip_effect_generator_top.sv @@
// Top level of the LED strip effect generator: controller plus datapath.
// Depends on lseg_pkg, lseg_channels, lseg_controller and lseg_datapath.

// Each tick, power-off or restore item is taken in the idle state and decoded
// in the cycle after. An item that yields no frame is done once decoded. A
// frame then sends one LED item per cycle, while the sink is ready, through a
// single output register; breathing first passes through three steps for the
// phase multiply, the sine table lookup and the colour scaling. The next item
// is accepted while the last LED of a frame still waits in the output
// register. Register writes are taken in any cycle and must only be issued
// while no frame is running.
module led_strip_effect_generator_top (
  input logic        clk,
  input logic        rst,
  lseg_in_if.sink    tick,
  lseg_out_if.source pixel,
  lseg_cfg_if.sink   cfg
);

  lseg_pkg::ctrl_cmd_t    cmd;
  lseg_pkg::ctrl_status_t status;

  // Sequencer
  lseg_controller u_controller (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  // Registers, arithmetic and output stage
  lseg_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .tick   (tick),
    .pixel  (pixel),
    .cfg    (cfg),
    .cmd    (cmd),
    .status (status)
  );

endmodule
